// ----- design/bssi_pkg.sv -----
package bssi_pkg;

  // one stored word
  typedef logic signed [31:0] word_t;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REVERSE = 2'd2,
    OP_INSERT  = 2'd3
  } op_t;

  // status codes of a result transaction
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // word returned by a pop on an empty stack
  localparam word_t EMPTY_WORD = -32'sd999;

  // sort keys for sorted insert, top of stack first: words not less than
  // the new word, then the new word, then the smaller words
  localparam logic [1:0] KEY_GE = 2'd0;
  localparam logic [1:0] KEY_X  = 2'd1;
  localparam logic [1:0] KEY_LT = 2'd2;

  // what every cell does in a cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_DN,
    CELL_SHIFT_UP,
    CELL_REV_INIT,
    CELL_SORT
  } cell_op_t;

  // broadcast control from the sequencer to the cell row
  typedef struct packed {
    cell_op_t op;
    logic     parity;
    word_t    value;
  } cell_ctl_t;

endpackage

// ----- design/bssi_cell.sv -----
module bssi_cell
  import bssi_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  cell_ctl_t                  ctl,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  word_t                      up_word,
  input  logic [$clog2(DEPTH+1)-1:0] up_key,
  input  word_t                      dn_word,
  input  logic [$clog2(DEPTH+1)-1:0] dn_key,
  output word_t                      word,
  output logic [$clog2(DEPTH+1)-1:0] key
);

  localparam int KW = $clog2(DEPTH+1);
  localparam logic [KW-1:0] IDX_K    = KW'(IDX);
  localparam logic [KW-1:0] KEY_NONE = '1;
  localparam logic          IDX_ODD  = ((IDX % 2) == 1);

  word_t         word_r, word_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic          is_left;

  // in a sort phase the cell pairs with the cell below when its index
  // parity matches the phase parity, otherwise with the cell above
  assign is_left = (IDX_ODD == ctl.parity);

  // next word and key
  always_comb begin
    word_nxt = word_r;
    key_nxt  = key_r;
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_SHIFT_DN: begin
        word_nxt = up_word;
        if (IDX == 0) begin
          key_nxt = KW'(KEY_X);
        end else if (IDX_K <= count) begin
          key_nxt = (up_word < ctl.value) ? KW'(KEY_LT) : KW'(KEY_GE);
        end else begin
          key_nxt = KEY_NONE;
        end
      end
      CELL_SHIFT_UP: begin
        word_nxt = dn_word;
      end
      CELL_REV_INIT: begin
        key_nxt = (IDX_K < count) ? (count - IDX_K - KW'(1)) : KEY_NONE;
      end
      CELL_SORT: begin
        if (is_left) begin
          if (key_r > dn_key) begin
            word_nxt = dn_word;
            key_nxt  = dn_key;
          end
        end else begin
          if (up_key > key_r) begin
            word_nxt = up_word;
            key_nxt  = up_key;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    key_r  <= key_nxt;
  end

  assign word = word_r;
  assign key  = key_r;

endmodule

// ----- design/bssi_ctrl.sv -----
module bssi_ctrl
  import bssi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_operation,
  input  word_t                      in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output word_t                      out_popped_word,
  output logic [1:0]                 out_status,
  output logic [4:0]                 out_fill_count,
  input  word_t                      top_word,
  output cell_ctl_t                  ctl,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int KW = $clog2(DEPTH+1);
  localparam int PW = $clog2(DEPTH+2);
  localparam logic [KW-1:0] FULL = KW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_DROP
  } state_t;

  state_t        state_r, state_nxt;
  logic [KW-1:0] count_r, count_nxt;
  logic [PW-1:0] phases_r, phases_nxt;
  logic          parity_r, parity_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  word_t         out_popped_r, out_popped_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [4:0]    out_fill_r, out_fill_nxt;
  logic [KW+4:0] fill_ext;
  logic          in_accept;
  op_t           op;

  assign op        = op_t'(in_operation);
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  // fill count of the result, taken from the count after the transaction
  assign fill_ext     = {5'b0, count_nxt};
  assign out_fill_nxt = fill_ext[4:0];

  // sequencer: push and pop handled in the idle state, multi-phase reverse and insert
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    phases_nxt     = phases_r;
    parity_nxt     = parity_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_popped_nxt = out_popped_r;
    out_status_nxt = out_status_r;
    ctl.op         = CELL_HOLD;
    ctl.parity     = parity_r;
    ctl.value      = in_value;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (op)
            OP_PUSH: begin
              out_valid_nxt  = 1'b1;
              out_popped_nxt = '0;
              if (count_r < FULL) begin
                ctl.op         = CELL_SHIFT_DN;
                count_nxt      = count_r + KW'(1);
                out_status_nxt = ST_OK;
              end else begin
                out_status_nxt = ST_OVERFLOW;
              end
            end
            OP_POP: begin
              out_valid_nxt = 1'b1;
              if (count_r != '0) begin
                ctl.op         = CELL_SHIFT_UP;
                count_nxt      = count_r - KW'(1);
                out_popped_nxt = top_word;
                out_status_nxt = ST_OK;
              end else begin
                out_popped_nxt = EMPTY_WORD;
                out_status_nxt = ST_EMPTY;
              end
            end
            OP_REVERSE: begin
              ctl.op     = CELL_REV_INIT;
              phases_nxt = PW'(count_r);
              parity_nxt = 1'b0;
              ovf_nxt    = 1'b0;
              state_nxt  = S_SORT;
            end
            OP_INSERT: begin
              ctl.op     = CELL_SHIFT_DN;
              phases_nxt = PW'(count_r) + PW'(1);
              parity_nxt = 1'b0;
              state_nxt  = S_SORT;
              if (count_r < FULL) begin
                count_nxt = count_r + KW'(1);
                ovf_nxt   = 1'b0;
              end else begin
                ovf_nxt   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SORT: begin
        if (phases_r != '0) begin
          ctl.op     = CELL_SORT;
          phases_nxt = phases_r - PW'(1);
          parity_nxt = !parity_r;
        end else if (ovf_r) begin
          state_nxt = S_DROP;
        end else begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_popped_nxt = '0;
          out_status_nxt = ST_OK;
        end
      end
      S_DROP: begin
        // the word left on top after the sort falls off a full stack
        ctl.op         = CELL_SHIFT_UP;
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_popped_nxt = '0;
        out_status_nxt = ST_OVERFLOW;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      phases_r    <= '0;
      parity_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      phases_r    <= phases_nxt;
      parity_r    <= parity_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_valid_nxt && !(out_valid_r && out_stall)) begin
      out_popped_r <= out_popped_nxt;
      out_status_r <= out_status_nxt;
      out_fill_r   <= out_fill_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_popped_word = out_popped_r;
  assign out_status      = out_status_r;
  assign out_fill_count  = out_fill_r;
  assign count           = count_r;

  // the stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("stack count above depth");

  // a pop on a non-empty stack removes exactly one word
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (op == OP_POP) && (count_r != '0)) |=>
      (count_r == $past(count_r) - KW'(1)))
    else $error("pop did not decrement count");

  // an empty status always carries the empty marker word
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_EMPTY)) |-> (out_popped_r == EMPTY_WORD))
    else $error("empty status without marker word");

  // the phase count of a sort never exceeds the depth plus one
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT) |-> (phases_r <= PW'(DEPTH + 1)))
    else $error("sort phase count out of range");

  // an overflowing insert leaves the stack full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DROP) |-> (count_r == FULL))
    else $error("drop cycle on a stack that is not full");

endmodule

// ----- design/bounded_stack_sorted_insert_top.sv -----
// push and pop: the result is valid in the cycle after the transaction is accepted
// reverse: key setup, sort phases; sorted insert: shift down, sort phases,
// plus a drop if full; a sort phase is an odd-even exchange along the cell row
// a new transaction is taken once the previous one is finished and its
// result register is free or being emptied
// synchronous active-low reset empties the stack; stored words are not cleared
module bounded_stack_sorted_insert_top
  import bssi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  word_t       in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output word_t       out_popped_word,
  output logic [1:0]  out_status,
  output logic [4:0]  out_fill_count
);

  localparam int KW = $clog2(DEPTH+1);

  cell_ctl_t     ctl;
  logic [KW-1:0] count;
  word_t         word_q [0:DEPTH];
  logic [KW-1:0] key_q  [0:DEPTH];

  bssi_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_popped_word(out_popped_word),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .top_word       (word_q[0]),
    .ctl            (ctl),
    .count          (count)
  );

  // cell row, top of stack in cell 0, one spare cell at the bottom
  for (genvar p = 0; p <= DEPTH; p++) begin : g_cell
    word_t         up_word, dn_word;
    logic [KW-1:0] up_key, dn_key;

    if (p == 0) begin : g_first
      assign up_word = ctl.value;
      assign up_key  = '0;
    end else begin : g_mid_up
      assign up_word = word_q[p-1];
      assign up_key  = key_q[p-1];
    end

    if (p == DEPTH) begin : g_last
      assign dn_word = '0;
      assign dn_key  = '1;
    end else begin : g_mid_dn
      assign dn_word = word_q[p+1];
      assign dn_key  = key_q[p+1];
    end

    bssi_cell #(
      .DEPTH(DEPTH),
      .IDX  (p)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .count  (count),
      .up_word(up_word),
      .up_key (up_key),
      .dn_word(dn_word),
      .dn_key (dn_key),
      .word   (word_q[p]),
      .key    (key_q[p])
    );
  end

endmodule
